// ----- hdl/sld_pkg.sv -----
// shared types, constants and helpers of the sarsa lambda update block
`timescale 1ns / 1ps
package sld_pkg;

  localparam int Q_W        = 32;
  localparam int FAC_W      = 17;
  localparam int IN_S_W     = 4;
  localparam int IN_A_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = 56;

  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd4;

  localparam logic [FAC_W-1:0] DISCOUNT_RST  = 17'd62259;
  localparam logic [FAC_W-1:0] STEP_SIZE_RST = 17'd6554;
  localparam logic [Q_W-1:0]   PRIOR_RST     = 32'd65536;
  localparam logic [FAC_W-1:0] ONE_Q16       = 17'd65536;
  localparam logic [Q_W-1:0]   CNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [Q_W-1:0]   CNT_STEP      = 32'd65536;

  localparam logic signed [SUM_W-1:0] SAT_HI = 56'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -56'sd2147483648;

  typedef struct packed {
    logic cfg_we;
    logic clr_go;
    logic clr_val;
    logic clr_cnt;
    logic clr_tr;
    logic latch;
    logic mul;
    logic tdsum;
    logic swp_go;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic have_last;
    logic clr_done;
    logic div_done;
    logic swp_done;
  } sts_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/sarsa_lambda_dirichlet_update.sv -----
// top level of the tabular sarsa lambda update with learned trace decay
//
// Command style input: an item (reward, next state, next action) is taken at
// a clock edge with start high and busy low. Each item gives one td_error,
// shown on out_td_error for one cycle with out_valid high; the receiver
// cannot hold it off. Configuration goes through cfg_valid/cfg_ready with a
// register index and data; cfg_ready is high only while the block is idle.
// The first item after reset only stores the state-action pair and returns
// zero without a pass over the tables. Later items run the read, multiply
// and td sum steps and a bit-serial divide for the decay, then one pass over
// every trace and value entry at one entry per cycle through a five stage
// pipeline. Items are processed one at a time; busy stays high until the result.
// After reset a clearing pass over every count entry fills the tables;
// writing prior_count runs that pass again for the counts and row totals
// only, and writing initial_value runs a shorter one over the values only,
// busy high throughout.
`timescale 1ns / 1ps
module sarsa_lambda_dirichlet_update import sld_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [Q_W-1:0] in_reward,
  input  logic [IN_S_W-1:0]     in_next_state,
  input  logic [IN_A_W-1:0]     in_next_action,
  output logic                  out_valid,
  output logic signed [Q_W-1:0] out_td_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
  );

  sld_dp #(.NUM_STATES(NUM_STATES), .NUM_ACTIONS(NUM_ACTIONS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_reward      (in_reward),
    .in_next_state  (in_next_state),
    .in_next_action (in_next_action),
    .out_td_error   (out_td_error)
  );

endmodule

// ----- hdl/sld_div.sv -----
// restoring divider for the trace decay, one quotient bit per cycle
`timescale 1ns / 1ps
module sld_div import sld_pkg::*; #(
  parameter int TOT_W = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [Q_W-1:0]   num,
  input  logic [TOT_W-1:0] den,
  output logic [FAC_W-1:0] quo,
  output logic             done
);

  localparam int STEP_W = $clog2(FAC_W);

  logic [TOT_W:0]      rem_r;
  logic [TOT_W-1:0]    den_r;
  logic [FAC_W-1:0]    quo_r;
  logic [STEP_W-1:0]   step_r;
  logic                run_r;
  logic                done_r;
  logic                qbit;
  logic [TOT_W:0]      rem_sub;

  assign qbit    = rem_r >= {1'b0, den_r};
  assign rem_sub = qbit ? rem_r - {1'b0, den_r} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      // a zero row total gives a zero decay
      run_r  <= den != '0;
      done_r <= den == '0;
      step_r <= '0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(FAC_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (TOT_W + 1)'(num);
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= {rem_sub[TOT_W-1:0], 1'b0};
      quo_r <= {quo_r[FAC_W-2:0], qbit};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- hdl/sld_ctrl.sv -----
// sequencer for clearing passes and the per-item update steps
`timescale 1ns / 1ps
module sld_ctrl import sld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  sts_t                 sts,
  output cmd_t                 cmd,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 out_valid
);

  typedef enum logic [3:0] {
    S_RST, S_CLR, S_IDLE, S_RD, S_MUL, S_TD, S_DIV, S_SWG, S_SWP, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   cfg_wr;
  logic   accept;

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_RST: begin
        cmd.clr_go  = 1'b1;
        cmd.clr_val = 1'b1;
        cmd.clr_cnt = 1'b1;
        cmd.clr_tr  = 1'b1;
        state_nxt   = S_CLR;
      end
      S_CLR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.cfg_we = cfg_wr;
        if (cfg_wr && (cfg_index == REG_PRIOR || cfg_index == REG_INIT)) begin
          cmd.clr_go  = 1'b1;
          cmd.clr_cnt = cfg_index == REG_PRIOR;
          cmd.clr_val = cfg_index == REG_INIT;
          state_nxt   = S_CLR;
        end else if (accept) begin
          cmd.latch = 1'b1;
          state_nxt = sts.have_last ? S_RD : S_OUT;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_TD;
      end
      S_TD: begin
        cmd.tdsum = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_SWG;
      end
      S_SWG: begin
        cmd.swp_go = 1'b1;
        state_nxt  = S_SWP;
      end
      S_SWP: begin
        if (sts.swp_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_RST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_OUT;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/sld_dp.sv -----
// datapath: tables, config registers, td arithmetic and the trace/value sweep
`timescale 1ns / 1ps
module sld_dp import sld_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [Q_W-1:0] in_reward,
  input  logic [IN_S_W-1:0]     in_next_state,
  input  logic [IN_A_W-1:0]     in_next_action,
  output logic signed [Q_W-1:0] out_td_error
);

  localparam int PAIRS = NUM_STATES * NUM_ACTIONS;
  localparam int CNTS  = PAIRS * NUM_STATES;
  localparam int SW    = $clog2(NUM_STATES);
  localparam int AW    = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int PW    = $clog2(PAIRS);
  localparam int CW    = $clog2(CNTS);
  localparam int TOT_W = Q_W + $clog2(NUM_STATES);

  // config registers
  logic [FAC_W-1:0]      disc_r, step_r;
  logic signed [Q_W-1:0] base_r, init_r;
  logic [Q_W-1:0]        prior_r;

  // item context
  logic signed [Q_W-1:0] reward_r, td_r;
  logic [PW-1:0]         nxt_pair_r, last_pair_r;
  logic [CW-1:0]         cidx_r;
  logic                  have_last_r;
  logic signed [49:0]    gprod_r;

  // tables
  logic signed [Q_W-1:0] vmem [PAIRS];
  logic [FAC_W-1:0]      trmem [PAIRS];
  logic [Q_W-1:0]        cmem [CNTS];
  logic [TOT_W-1:0]      tmem [PAIRS];
  logic signed [Q_W-1:0] qa_r, qb_r;
  logic [FAC_W-1:0]      tr_rd_r;
  logic [Q_W-1:0]        cnt_rd_r;
  logic [TOT_W-1:0]      tot_rd_r;

  // clearing pass
  logic          clr_act_r, clr_val_f, clr_cnt_f, clr_tr_f;
  logic [CW-1:0] clr_idx_r;
  logic          clr_lo, clr_done;
  logic [PW-1:0] clr_pa;

  // sweep pipeline
  logic                  sw_act_r;
  logic [PW-1:0]         sw_idx_r;
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [PW-1:0]         a1_r, a2_r, a3_r, a4_r;
  logic signed [Q_W-1:0] q2_r, q3_r, q4_r;
  logic [FAC_W-1:0]      t2_r;
  logic [17:0]           f3_r;
  logic signed [50:0]    p4_r;

  logic [SW-1:0]         ns_c;
  logic [AW-1:0]         na_c;
  logic [PW-1:0]         nxt_pair, rda;
  logic [CW-1:0]         cidx;
  logic [FAC_W-1:0]      decay;
  logic                  div_done;
  logic [Q_W-1:0]        room, added;
  logic [TOT_W-1:0]      tot_init;
  logic signed [49:0]    g_rnd;
  logic signed [Q_W-1:0] td_nxt;
  logic [34:0]           s1, s2;
  logic [FAC_W-1:0]      tn;
  logic signed [50:0]    p_rnd;
  logic signed [Q_W-1:0] q_new;

  always_comb begin
    if (int'(in_next_state) >= NUM_STATES) begin
      ns_c = SW'(NUM_STATES - 1);
    end else begin
      ns_c = SW'(in_next_state);
    end
    if (int'(in_next_action) >= NUM_ACTIONS) begin
      na_c = AW'(NUM_ACTIONS - 1);
    end else begin
      na_c = AW'(in_next_action);
    end
  end

  assign nxt_pair = PW'(ns_c) * PW'(NUM_ACTIONS) + PW'(na_c);
  assign cidx     = CW'(last_pair_r) * CW'(NUM_STATES) + CW'(ns_c);

  assign clr_lo   = clr_idx_r < CW'(PAIRS);
  assign clr_pa   = clr_idx_r[PW-1:0];
  assign clr_done = clr_act_r &&
                    (clr_idx_r == (clr_cnt_f ? CW'(CNTS - 1) : CW'(PAIRS - 1)));
  assign tot_init = TOT_W'(prior_r) * TOT_W'(NUM_STATES);

  // saturating count increment by one in Q16.16
  assign room  = CNT_MAX - cnt_rd_r;
  assign added = (room > CNT_STEP) ? CNT_STEP : room;

  assign g_rnd  = (gprod_r + 50'sd32768) >>> 16;
  assign td_nxt = sat32(SUM_W'(reward_r) - SUM_W'(base_r) + SUM_W'(g_rnd) - SUM_W'(qb_r));

  assign s1 = 35'(tr_rd_r) * 35'(decay) + 35'd32768;
  assign tn = (a1_r == last_pair_r) ? ONE_Q16 : s1[32:16];
  assign s2 = 35'(t2_r) * 35'(step_r) + 35'd32768;

  assign p_rnd = (p4_r + 51'sd32768) >>> 16;
  assign q_new = sat32(SUM_W'(q4_r) + SUM_W'(p_rnd));

  assign rda = sw_act_r ? sw_idx_r : nxt_pair_r;

  sld_div #(.TOT_W(TOT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul),
    .num   (cnt_rd_r),
    .den   (tot_rd_r),
    .quo   (decay),
    .done  (div_done)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_r      <= DISCOUNT_RST;
      step_r      <= STEP_SIZE_RST;
      base_r      <= '0;
      prior_r     <= PRIOR_RST;
      init_r      <= '0;
      have_last_r <= 1'b0;
      last_pair_r <= '0;
      clr_act_r   <= 1'b0;
      clr_val_f   <= 1'b0;
      clr_cnt_f   <= 1'b0;
      clr_tr_f    <= 1'b0;
      clr_idx_r   <= '0;
      sw_act_r    <= 1'b0;
      sw_idx_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          REG_DISCOUNT:  disc_r  <= cfg_data[FAC_W-1:0];
          REG_STEP_SIZE: step_r  <= cfg_data[FAC_W-1:0];
          REG_BASELINE:  base_r  <= cfg_data;
          REG_PRIOR:     prior_r <= cfg_data;
          REG_INIT:      init_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fin) begin
        have_last_r <= 1'b1;
        last_pair_r <= nxt_pair_r;
      end
      if (cmd.clr_go) begin
        clr_act_r <= 1'b1;
        clr_idx_r <= '0;
        clr_val_f <= cmd.clr_val;
        clr_cnt_f <= cmd.clr_cnt;
        clr_tr_f  <= cmd.clr_tr;
      end else if (clr_act_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_done) clr_act_r <= 1'b0;
      end
      if (cmd.swp_go) begin
        sw_act_r <= 1'b1;
        sw_idx_r <= '0;
      end else if (sw_act_r) begin
        sw_idx_r <= sw_idx_r + 1'b1;
        if (sw_idx_r == PW'(PAIRS - 1)) sw_act_r <= 1'b0;
      end
      v1_r <= sw_act_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // item payload and sweep stages
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      reward_r   <= in_reward;
      nxt_pair_r <= nxt_pair;
      cidx_r     <= cidx;
      td_r       <= '0;
    end
    if (cmd.mul) gprod_r <= $signed({1'b0, disc_r}) * qa_r;
    if (cmd.tdsum) td_r <= td_nxt;
    a1_r <= sw_idx_r;
    a2_r <= a1_r;
    a3_r <= a2_r;
    a4_r <= a3_r;
    q2_r <= qa_r;
    q3_r <= q2_r;
    q4_r <= q3_r;
    t2_r <= tn;
    f3_r <= s2[33:16];
    p4_r <= $signed({1'b0, f3_r}) * td_r;
  end

  // value table
  always_ff @(posedge clk) begin
    if (clr_act_r && clr_val_f && clr_lo) begin
      vmem[clr_pa] <= init_r;
    end else if (v4_r) begin
      vmem[a4_r] <= q_new;
    end
    qa_r <= vmem[rda];
    qb_r <= vmem[last_pair_r];
  end

  // trace table
  always_ff @(posedge clk) begin
    if (clr_act_r && clr_tr_f && clr_lo) begin
      trmem[clr_pa] <= '0;
    end else if (v2_r) begin
      trmem[a2_r] <= t2_r;
    end
    tr_rd_r <= trmem[sw_idx_r];
  end

  // transition counts
  always_ff @(posedge clk) begin
    if (clr_act_r && clr_cnt_f) begin
      cmem[clr_idx_r] <= prior_r;
    end else if (cmd.mul) begin
      cmem[cidx_r] <= cnt_rd_r + added;
    end
    cnt_rd_r <= cmem[cidx_r];
  end

  // row totals
  always_ff @(posedge clk) begin
    if (clr_act_r && clr_cnt_f && clr_lo) begin
      tmem[clr_pa] <= tot_init;
    end else if (cmd.mul) begin
      tmem[last_pair_r] <= tot_rd_r + TOT_W'(added);
    end
    tot_rd_r <= tmem[last_pair_r];
  end

  assign sts.have_last = have_last_r;
  assign sts.clr_done  = clr_done;
  assign sts.div_done  = div_done;
  assign sts.swp_done  = v4_r && (a4_r == PW'(PAIRS - 1));
  assign out_td_error  = td_r;

endmodule

// ----- tb/sv/sld_checker.sv -----
// td error predictor and scoreboard for the sarsa lambda update block
`timescale 1ns / 1ps
module sld_checker import sld_pkg::*; #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic signed [Q_W-1:0] in_reward,
  input  logic [IN_S_W-1:0]     in_next_state,
  input  logic [IN_A_W-1:0]     in_next_action,
  input  logic                  out_valid,
  input  logic signed [Q_W-1:0] out_td_error,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int PAIRS = NUM_STATES * NUM_ACTIONS;

  longint gamma_q, alpha_q, baseline_q, prior_q, init_q;
  longint q_val [PAIRS];
  longint elig [PAIRS];
  longint trans_cnt [PAIRS*NUM_STATES];
  longint row_total [PAIRS];
  int prev_s, prev_a;
  bit prev_valid;
  logic signed [Q_W-1:0] td_expected [$];

  initial pending = 0;

  function automatic longint round16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic refill_counts();
    for (int p = 0; p < PAIRS; p++) begin
      for (int s = 0; s < NUM_STATES; s++) trans_cnt[p*NUM_STATES+s] = prior_q;
      row_total[p] = NUM_STATES * prior_q;
    end
  endtask

  task automatic refill_values();
    for (int p = 0; p < PAIRS; p++) q_val[p] = init_q;
  endtask

  task automatic predict_td(input logic signed [Q_W-1:0] rew, input int ns_in,
                            input int na_in);
    longint td, decay, room, fac;
    int ns, na, prv, ci;
    td = 0;
    ns = (ns_in >= NUM_STATES) ? NUM_STATES - 1 : ns_in;
    na = (na_in >= NUM_ACTIONS) ? NUM_ACTIONS - 1 : na_in;
    if (prev_valid) begin
      prv = prev_s * NUM_ACTIONS + prev_a;
      ci = prv * NUM_STATES + ns;
      td = longint'(rew) - baseline_q + round16(gamma_q * q_val[ns*NUM_ACTIONS+na])
           - q_val[prv];
      td = clip32(td);
      decay = (row_total[prv] > 0) ? (trans_cnt[ci] << 16) / row_total[prv] : 0;
      room = 64'hFFFF_FFFF - trans_cnt[ci];
      if (room > 65536) room = 65536;
      trans_cnt[ci] += room;
      row_total[prv] += room;
      for (int i = 0; i < PAIRS; i++) elig[i] = (elig[i] * decay + 32768) >> 16;
      elig[prv] = 65536;
      for (int i = 0; i < PAIRS; i++) begin
        fac = (elig[i] * alpha_q + 32768) >> 16;
        q_val[i] = clip32(q_val[i] + round16(fac * td));
      end
    end
    prev_s = ns;
    prev_a = na;
    prev_valid = 1'b1;
    td_expected.push_back(td[Q_W-1:0]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gamma_q = DISCOUNT_RST;
      alpha_q = STEP_SIZE_RST;
      baseline_q = 0;
      prior_q = PRIOR_RST;
      init_q = 0;
      refill_values();
      refill_counts();
      for (int i = 0; i < PAIRS; i++) elig[i] = 0;
      prev_s = 0;
      prev_a = 0;
      prev_valid = 1'b0;
      td_expected.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DISCOUNT:  gamma_q = cfg_data[FAC_W-1:0];
          REG_STEP_SIZE: alpha_q = cfg_data[FAC_W-1:0];
          REG_BASELINE:  baseline_q = longint'($signed(cfg_data));
          REG_PRIOR: begin
            prior_q = cfg_data;
            refill_counts();
          end
          REG_INIT: begin
            init_q = longint'($signed(cfg_data));
            refill_values();
          end
          default: ;
        endcase
      end
      if (start && !busy) predict_td(in_reward, in_next_state, in_next_action);
      if (out_valid) begin
        if (td_expected.size() == 0) begin
          $error("td_error: no item outstanding, got %0d", out_td_error);
          fail_count++;
        end else begin
          if (out_td_error !== td_expected[0]) begin
            $error("td_error: expected %0d, actual %0d", td_expected[0], out_td_error);
            fail_count++;
          end
          void'(td_expected.pop_front());
        end
      end
    end
    pending = td_expected.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// stimulus and verdict for the sarsa lambda update block
`timescale 1ns / 1ps
module tb_top import sld_pkg::*;;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [Q_W-1:0] in_reward;
  logic [IN_S_W-1:0] in_next_state;
  logic [IN_A_W-1:0] in_next_action;
  logic out_valid;
  logic signed [Q_W-1:0] out_td_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int pending;

  sarsa_lambda_dirichlet_update dut (.*);

  sld_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("sarsa_lambda_dirichlet_update test failed");
    $finish;
  end

  task automatic send_item(input logic [31:0] rew, input int s, input int a);
    start <= 1'b1;
    in_reward <= rew;
    in_next_state <= s[IN_S_W-1:0];
    in_next_action <= a[IN_A_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // mostly back to back or short gaps, now and then a long one
  task automatic sender_gap();
    int r, g;
    r = $urandom_range(0, 99);
    if (r < 40) g = 0;
    else if (r < 92) g = $urandom_range(1, 4);
    else g = $urandom_range(20, 150);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_factor();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'd131071;
      default: return $urandom_range(0, 131071);
    endcase
  endfunction

  function automatic logic [31:0] pick_reward();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 32'h60000) - 32'h30000;
    if (r < 85) return $urandom;
    if (r < 92) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  initial begin
    int s, a, phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_reward = '0;
    in_next_state = '0;
    in_next_action = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // first step, full-scale rewards, corner states and actions, repeated pairs
    send_item(32'h7FFF_FFFF, 15, 3);
    send_item(32'h7FFF_FFFF, 0, 0);
    send_item(32'h8000_0000, 15, 3);
    send_item(32'h0, 0, 3);
    send_item(32'hFFFF_FFFF, 15, 0);
    send_item(32'h1, 15, 0);
    send_item(32'h0001_0000, 15, 0);
    send_item(32'h0001_0000, 15, 0);
    sender_gap();
    send_item(32'hFFFF_0000, 7, 2);
    send_item(32'h5555_5555, 7, 2);
    send_item(32'hAAAA_AAAA, 10, 1);
    send_item(32'h8000_0000, 0, 0);
    send_item(32'h8000_0000, 0, 0);
    sender_gap();
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DISCOUNT, 32'd0);
          write_reg(REG_STEP_SIZE, 32'd0);
          write_reg(REG_BASELINE, 32'h8000_0000);
          write_reg(REG_PRIOR, 32'd0);
          write_reg(REG_INIT, 32'h8000_0000);
          write_reg(3'd5, $urandom);
          write_reg(3'd6, $urandom);
          write_reg(3'd7, $urandom);
        end
        1: begin
          write_reg(REG_DISCOUNT, 32'd131071);
          write_reg(REG_STEP_SIZE, 32'd131071);
          write_reg(REG_BASELINE, 32'h7FFF_FFFF);
          write_reg(REG_PRIOR, 32'hFFFF_FFFF);
          write_reg(REG_INIT, 32'h7FFF_FFFF);
        end
        2: begin
          // counts close to saturation
          write_reg(REG_PRIOR, 32'hFFFE_8000);
          write_reg(REG_DISCOUNT, 32'd65536);
          write_reg(REG_STEP_SIZE, 32'd65536);
          write_reg(REG_INIT, 32'd0);
          write_reg(REG_BASELINE, 32'd0);
        end
        default: begin
          write_reg(REG_DISCOUNT, pick_factor());
          write_reg(REG_STEP_SIZE, pick_factor());
          write_reg(REG_BASELINE, ($urandom_range(0, 1) != 0) ? $urandom
                                  : $urandom_range(0, 32'h40000) - 32'h20000);
          write_reg(REG_PRIOR, ($urandom_range(0, 2) == 0) ? $urandom
                               : $urandom_range(1, 32'h40000));
          write_reg(REG_INIT, ($urandom_range(0, 1) != 0) ? $urandom
                              : $urandom_range(0, 32'h80000) - 32'h40000);
        end
      endcase
      repeat (230) begin
        // favor a few states so counts and decays build up
        s = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        a = $urandom_range(0, 3);
        send_item(pick_reward(), s, a);
        sender_gap();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("sarsa_lambda_dirichlet_update test passed");
    end else begin
      $display("sarsa_lambda_dirichlet_update test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sld_pkg.sv
hdl/sld_div.sv
hdl/sld_ctrl.sv
hdl/sld_dp.sv
hdl/sarsa_lambda_dirichlet_update.sv
tb/sv/sld_checker.sv
tb/sv/tb_top.sv
